### design/fme_pkg.sv
// shared types, constants and divider step for the fuzzy membership evaluator
// no dependencies; used by all design files
package fme_pkg;

  localparam int ValueWidth = 16;
  localparam int DistWidth  = ValueWidth + 1;
  localparam int DegWidth   = 17;
  localparam int DivStages  = 17;
  localparam logic [DegWidth-1:0] OneQ16 = 17'h10000;

  typedef enum logic [2:0] {
    SHAPE_TRI   = 3'd0,
    SHAPE_TRAP  = 3'd1,
    SHAPE_PI    = 3'd2,
    SHAPE_S     = 3'd3,
    SHAPE_Z     = 3'd4
  } shape_e;

  typedef enum logic [2:0] {
    CFG_SHAPE   = 3'd0,
    CFG_POINT_A = 3'd1,
    CFG_POINT_B = 3'd2,
    CFG_POINT_C = 3'd3,
    CFG_POINT_D = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_ZERO,
    OP_ONE,
    OP_LIN,
    OP_SQ,
    OP_ONE_SQ
  } op_e;

  // item between classifier and divider
  typedef struct packed {
    op_e                  op;
    logic [DistWidth-1:0] delta;
    logic [DistWidth-1:0] width;
  } seg_t;

  // item inside the divider pipeline
  typedef struct packed {
    op_e                  op;
    logic [DistWidth-1:0] rem;
    logic [DistWidth-1:0] width;
    logic [DegWidth-1:0]  quo;
  } div_t;

  // one restoring division step; the first step compares without shifting
  function automatic div_t fme_div_step(div_t s, logic first);
    logic [DistWidth-1:0] sh;
    logic                 ge;
    div_t                 r;
    sh = first ? s.rem : {s.rem[DistWidth-2:0], 1'b0};
    ge = (sh >= s.width);
    r = s;
    r.rem = ge ? (sh - s.width) : sh;
    r.quo = {s.quo[DegWidth-2:0], ge};
    return r;
  endfunction

endpackage

### design/fme_classify.sv
// region classifier: picks operation, distance and segment width per sample
// depends on fme_pkg
module fme_classify import fme_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [2:0]                   shape_i,
  input  logic signed [ValueWidth-1:0] pa_i,
  input  logic signed [ValueWidth-1:0] pb_i,
  input  logic signed [ValueWidth-1:0] pc_i,
  input  logic signed [ValueWidth-1:0] pd_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ValueWidth-1:0] x_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output seg_t                         out_o
);

  logic v_q;
  seg_t s_q, s_d;
  logic signed [DistWidth-1:0] x, a, b, c, d;
  logic signed [DistWidth:0]   x2, ab, cd;

  assign x = DistWidth'(x_i);
  assign a = DistWidth'(pa_i);
  assign b = DistWidth'(pb_i);
  assign c = DistWidth'(pc_i);
  assign d = DistWidth'(pd_i);
  assign x2 = {x, 1'b0};
  assign ab = (DistWidth+1)'(a) + (DistWidth+1)'(b);
  assign cd = (DistWidth+1)'(c) + (DistWidth+1)'(d);

  // region decode
  always_comb begin
    s_d.op = OP_ZERO;
    s_d.delta = '0;
    s_d.width = '0;
    case (shape_i)
      SHAPE_TRI: begin
        if (x <= a) s_d.op = OP_ZERO;
        else if (x <= b) begin
          s_d = '{OP_LIN, x - a, b - a};
        end else if (x <= c) begin
          s_d = '{OP_LIN, c - x, c - b};
        end
      end
      SHAPE_TRAP: begin
        if (x <= a) s_d.op = OP_ZERO;
        else if (x <= b) s_d = '{OP_LIN, x - a, b - a};
        else if (x <= c) s_d.op = OP_ONE;
        else if (x <= d) s_d = '{OP_LIN, d - x, d - c};
      end
      SHAPE_PI: begin
        if (x <= a) s_d.op = OP_ZERO;
        else if (x2 <= ab) s_d = '{OP_SQ, x - a, b - a};
        else if (x <= b) s_d = '{OP_ONE_SQ, b - x, b - a};
        else if (x <= c) s_d.op = OP_ONE;
        else if (x2 <= cd) s_d = '{OP_ONE_SQ, x - c, d - c};
        else if (x <= d) s_d = '{OP_SQ, d - x, d - c};
      end
      SHAPE_S: begin
        if (x <= a) s_d.op = OP_ZERO;
        else if (x >= b) s_d.op = OP_ONE;
        else if (x2 <= ab) s_d = '{OP_SQ, x - a, b - a};
        else s_d = '{OP_ONE_SQ, b - x, b - a};
      end
      SHAPE_Z: begin
        if (x <= a) s_d.op = OP_ONE;
        else if (x >= b) s_d.op = OP_ZERO;
        else if (x2 <= ab) s_d = '{OP_ONE_SQ, x - a, b - a};
        else s_d = '{OP_SQ, b - x, b - a};
      end
      default: s_d.op = OP_ZERO;
    endcase
  end

  assign in_ready_o = !v_q || out_ready_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s_q <= s_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_o = s_q;

endmodule

### design/fme_divider.sv
// pipelined restoring divider, one quotient bit per stage
// depends on fme_pkg
module fme_divider import fme_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  seg_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output div_t out_o
);

  logic [DivStages-1:0] v_q;
  logic [DivStages-1:0] adv;
  div_t                 st_q [DivStages];
  div_t                 src  [DivStages];
  logic [DivStages-1:0] src_v;

  // stage may load when empty or when its item moves on
  always_comb begin
    adv[DivStages-1] = !v_q[DivStages-1] || out_ready_i;
    for (int k = DivStages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  genvar g;
  generate
    for (g = 0; g < DivStages; g++) begin : g_stage
      if (g == 0) begin : g_first
        assign src[g] = '{in_i.op, in_i.delta, in_i.width, '0};
        assign src_v[g] = in_valid_i;
      end else begin : g_rest
        assign src[g] = st_q[g-1];
        assign src_v[g] = v_q[g-1];
      end

      // valid bit
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (adv[g]) begin
          v_q[g] <= src_v[g];
        end
      end

      // one division step
      always_ff @(posedge clk_i) begin
        if (adv[g] && src_v[g]) begin
          st_q[g] <= fme_div_step(src[g], (g == 0));
        end
      end
    end
  endgenerate

  assign out_valid_o = v_q[DivStages-1];
  assign out_o = st_q[DivStages-1];

endmodule

### design/fme_shape_out.sv
// squaring stage and final degree selection with output register
// depends on fme_pkg
module fme_shape_out import fme_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  div_t                in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DegWidth-1:0] degree_o
);

  logic                    v1_q, v2_q;
  logic                    adv1, adv2;
  op_e                     op_q;
  logic [DegWidth-1:0]     r_q;
  logic [2*DegWidth-1:0]   sq_q;
  logic [DegWidth-1:0]     ts;
  logic [DegWidth-1:0]     deg_d, deg_q;

  assign adv2 = !v2_q || out_ready_i;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  // square of the ratio
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      op_q <= in_i.op;
      r_q  <= in_i.quo;
      sq_q <= in_i.quo * in_i.quo;
    end
  end

  // 2*r*r in q16
  assign ts = sq_q[DegWidth+14:15];

  always_comb begin
    case (op_q)
      OP_ZERO:   deg_d = '0;
      OP_ONE:    deg_d = OneQ16;
      OP_LIN:    deg_d = r_q;
      OP_SQ:     deg_d = ts;
      OP_ONE_SQ: deg_d = OneQ16 - ts;
      default:   deg_d = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      deg_q <= deg_d;
    end
  end

  assign out_valid_o = v2_q;
  assign degree_o = deg_q;

endmodule

### design/fuzzy_membership_eval_core.sv
// fuzzy membership evaluator top level: config registers and pipeline
// 20 register stages: classify 1, divider 17 (one quotient bit each), square 1, output 1
// throughput one item per cycle; each stage holds its item while downstream stalls
// reset clears all valid bits and sets shape and break points to zero
// depends on fme_pkg, fme_classify, fme_divider, fme_shape_out
module fuzzy_membership_eval_core import fme_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [ValueWidth-1:0]        cfg_data_i,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic signed [ValueWidth-1:0] sample_value_i,
  output logic                         degree_valid_o,
  input  logic                         degree_ready_i,
  output logic [DegWidth-1:0]          degree_o
);

  logic [2:0]                   shape_q;
  logic signed [ValueWidth-1:0] pa_q, pb_q, pc_q, pd_q;
  logic                         cv, cr, dv, dr;
  seg_t                         seg;
  div_t                         dq;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
      pd_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHAPE:   shape_q <= cfg_data_i[2:0];
        CFG_POINT_A: pa_q <= cfg_data_i;
        CFG_POINT_B: pb_q <= cfg_data_i;
        CFG_POINT_C: pc_q <= cfg_data_i;
        CFG_POINT_D: pd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fme_classify u_classify (
    .clk_i, .rst_ni,
    .shape_i(shape_q), .pa_i(pa_q), .pb_i(pb_q), .pc_i(pc_q), .pd_i(pd_q),
    .in_valid_i(sample_valid_i), .in_ready_o(sample_ready_o), .x_i(sample_value_i),
    .out_valid_o(cv), .out_ready_i(cr), .out_o(seg)
  );

  fme_divider u_divider (
    .clk_i, .rst_ni,
    .in_valid_i(cv), .in_ready_o(cr), .in_i(seg),
    .out_valid_o(dv), .out_ready_i(dr), .out_o(dq)
  );

  fme_shape_out u_shape_out (
    .clk_i, .rst_ni,
    .in_valid_i(dv), .in_ready_o(dr), .in_i(dq),
    .out_valid_o(degree_valid_o), .out_ready_i(degree_ready_i), .degree_o(degree_o)
  );

endmodule

### tb/tb_fuzzy_membership_eval_core.sv
// testbench for the fuzzy membership evaluator core: directed table, then random items
// checks each degree against an in-bench predictor; depends on fme_pkg and the core
module tb_fuzzy_membership_eval_core;
  import fme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int RandomItems = 500;
  localparam int LongStall = 300;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [2:0]                   cfg_index_i;
  logic [ValueWidth-1:0]        cfg_data_i;
  logic                         sample_valid_i;
  logic                         sample_ready_o;
  logic signed [ValueWidth-1:0] sample_value_i;
  logic                         degree_valid_o;
  logic                         degree_ready_i;
  logic [DegWidth-1:0]          degree_o;

  fuzzy_membership_eval_core i_dut (.*);

  // predictor copy of the configuration
  shape_e             cur_shape;
  logic signed [15:0] pt_a, pt_b, pt_c, pt_d;

  logic [DegWidth-1:0] degree_queue[$];
  int                  error_count;
  int                  cycle_count;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  bit                  hold_off;
  bit                  hold_go;

  // directed rows: shape, a, b, c, d, sample, expected degree (-1 = use predictor)
  typedef struct {
    logic [2:0] shape;
    int         a, b, c, d, x, want;
  } row_t;
  row_t rows[$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // floor(delta * 2^16 / width)
  function automatic longint ratio_q16(longint delta, longint width);
    return (delta <<< 16) / width;
  endfunction

  function automatic longint twice_sq(longint delta, longint width);
    longint r;
    r = ratio_q16(delta, width);
    return (2 * r * r) >>> 16;
  endfunction

  function automatic longint membership(longint x);
    longint a, b, c, d, one;
    a = pt_a; b = pt_b; c = pt_c; d = pt_d; one = 65536;
    case (cur_shape)
      SHAPE_TRI: begin
        if (x <= a) return 0;
        if (x <= b) return ratio_q16(x - a, b - a);
        if (x <= c) return ratio_q16(c - x, c - b);
        return 0;
      end
      SHAPE_TRAP: begin
        if (x <= a) return 0;
        if (x <= b) return ratio_q16(x - a, b - a);
        if (x <= c) return one;
        if (x <= d) return ratio_q16(d - x, d - c);
        return 0;
      end
      SHAPE_PI: begin
        if (x <= a) return 0;
        if (2 * x <= a + b) return twice_sq(x - a, b - a);
        if (x <= b) return one - twice_sq(b - x, b - a);
        if (x <= c) return one;
        if (2 * x <= c + d) return one - twice_sq(x - c, d - c);
        if (x <= d) return twice_sq(d - x, d - c);
        return 0;
      end
      SHAPE_S: begin
        if (x <= a) return 0;
        if (x >= b) return one;
        if (2 * x <= a + b) return twice_sq(x - a, b - a);
        return one - twice_sq(b - x, b - a);
      end
      SHAPE_Z: begin
        if (x <= a) return one;
        if (x >= b) return 0;
        if (2 * x <= a + b) return one - twice_sq(x - a, b - a);
        return twice_sq(b - x, b - a);
      end
      default: return 0;
    endcase
  endfunction

  // config write, only while idle
  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SHAPE:   cur_shape = shape_e'(data[2:0]);
      CFG_POINT_A: pt_a = data;
      CFG_POINT_B: pt_b = data;
      CFG_POINT_C: pt_c = data;
      default:     pt_d = data;
    endcase
    @(posedge clk_i);
  endtask

  // out-of-range index must be ignored
  task automatic write_bad_index(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(logic [2:0] s, int a, int b, int c, int d);
    write_reg(CFG_SHAPE, 16'(s));
    write_reg(CFG_POINT_A, 16'(a));
    write_reg(CFG_POINT_B, 16'(b));
    write_reg(CFG_POINT_C, 16'(c));
    write_reg(CFG_POINT_D, 16'(d));
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    sample_valid_i <= 1'b0;
    while (degree_queue.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  // valid stays high into the next item when no idle cycle is drawn
  task automatic send_sample(logic [15:0] x, int want);
    logic [DegWidth-1:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pred = DegWidth'(membership($signed(x)));
    if (want >= 0 && DegWidth'(want) != pred) begin
      $error("degree table: expected %0d predicted %0d", want, pred);
      error_count++;
    end
    degree_queue.push_back(pred);
    sample_valid_i <= 1'b1;
    sample_value_i <= x;
    do @(posedge clk_i); while (!sample_ready_o);
  endtask

  // ordered points with random spacing, sometimes degenerate
  function automatic int rand_point(int lo);
    int span;
    span = ($urandom_range(3) == 0) ? 0 : $urandom_range(($urandom_range(1)) ? 40 : 4000);
    return (lo + span > 32767) ? 32767 : lo + span;
  endfunction

  task automatic random_config();
    int a, b, c, d;
    if ($urandom_range(9) == 0) begin
      set_shape(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
    end else begin
      a = $urandom_range(9) == 0 ? -32768 : int'($urandom_range(60000)) - 32768;
      b = rand_point(a);
      c = rand_point(b);
      d = $urandom_range(9) == 0 ? 32767 : rand_point(c);
      set_shape(3'($urandom_range(4)), a, b, c, d);
    end
  endtask

  task automatic random_sample();
    int x;
    case ($urandom_range(4))
      0: x = $urandom;
      1: x = int'(pt_a) + int'($urandom_range(8)) - 4;
      2: x = int'(pt_b) + int'($urandom_range(8)) - 4;
      default: x = int'(pt_a) + int'($urandom_range(
                     (pt_d > pt_a) ? int'(pt_d) - int'(pt_a) + 2 : 8)) - 1;
    endcase
    send_sample(16'(x), -1);
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) degree_ready_i <= 1'b0;
    else degree_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each accepted degree against the oldest prediction
  always @(posedge clk_i) begin
    logic [DegWidth-1:0] want;
    if (rst_ni && degree_valid_o && degree_ready_i) begin
      if (degree_queue.size() == 0) begin
        $error("degree: unexpected item %0d", degree_o);
        error_count++;
      end else begin
        want = degree_queue.pop_front();
        if (degree_o !== want) begin
          $error("degree: expected %0d actual %0d", want, degree_o);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps streaming
  initial begin
    int stall_count;
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    for (stall_count = 0; stall_count < LongStall; stall_count++) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    row_t r;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    sample_valid_i = 1'b0;
    sample_value_i = '0;
    cur_shape = SHAPE_TRI;
    pt_a = 0; pt_b = 0; pt_c = 0; pt_d = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: all points zero, triangle gives zero everywhere
    send_sample(16'h8000, 0);
    send_sample(16'h7fff, 0);
    send_sample(16'h0000, 0);
    drain();

    rows = '{
      '{SHAPE_TRI, -256, 0, 256, 0, 128, 32768},
      '{SHAPE_TRI, -256, 0, 256, 0, 0, 65536},
      '{SHAPE_TRI, -32768, 0, 32767, 0, -32767, -1},
      '{SHAPE_TRI, -32768, 32767, 32767, 0, 32767, 65536},
      '{SHAPE_TRAP, -512, -256, 256, 512, 0, 65536},
      '{SHAPE_TRAP, -512, -256, 256, 512, 384, 32768},
      '{SHAPE_TRAP, -512, -256, 256, 512, 600, 0},
      '{SHAPE_TRAP, 10, 10, 10, 10, 10, 0},
      '{SHAPE_PI, -512, 0, 0, 512, -256, 32768},
      '{SHAPE_PI, -512, 0, 0, 512, -255, -1},
      '{SHAPE_PI, -512, 0, 0, 512, 256, 32768},
      '{SHAPE_PI, -512, 0, 0, 512, 511, -1},
      '{SHAPE_PI, -512, 0, 0, 512, 32767, 0},
      '{SHAPE_S, -32768, 32767, 0, 0, 0, -1},
      '{SHAPE_S, -100, 100, 0, 0, 100, 65536},
      '{SHAPE_S, -100, 100, 0, 0, -100, 0},
      '{SHAPE_S, -100, 100, 0, 0, 1, -1},
      '{SHAPE_Z, -100, 100, 0, 0, -100, 65536},
      '{SHAPE_Z, -100, 100, 0, 0, 100, 0},
      '{SHAPE_Z, -100, 100, 0, 0, -1, -1},
      '{SHAPE_Z, 200, -200, 0, 0, 0, 65536},
      '{3'd5, -100, 100, 0, 0, 0, 0},
      '{3'd7, -100, 100, 0, 0, 5, 0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      set_shape(r.shape, r.a, r.b, r.c, r.d);
      if (i == 3) write_bad_index(3'd6, 16'h1234);
      send_sample(16'(r.x), r.want);
      drain();
    end

    // random part in idling phases
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 25 == 0) begin
        drain();
        random_config();
        case ((n / 25) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
          default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
        if (n == 0) hold_go = 1'b1;
      end
      random_sample();
    end

    drain();
    if (error_count == 0 && degree_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
